// File: src/sleep_queue_wakeup_table_macros.svh
// assertion macros for the sleep queue wake-up table
// no dependencies; included by the top level only
`ifndef SLEEP_QUEUE_WAKEUP_TABLE_MACROS_SVH
`define SLEEP_QUEUE_WAKEUP_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define SQWT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("sqwt assertion failed");
// condition must never be true outside reset
`define SQWT_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("sqwt forbidden condition seen");
`else
`define SQWT_ASSERT(label, clk, rst_n, prop)
`define SQWT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: src/sqwt_pkg.sv
// shared types and constants for the sleep queue wake-up table
// no dependencies
package sqwt_pkg;

    localparam int ID_W     = 16;
    localparam int TICK_W   = 63;
    localparam int STATUS_W = 2;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WOKEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // request type codes
    localparam logic REQ_SLEEP = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESP,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_sleep;
        logic load_tick;
        logic scan_step;
        logic scan_finish;
        logic resp_load;
        logic emit_read;
        logic emit_load;
    } t_ctl;

    // status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic any_woken;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage

// File: src/sqwt_if.sv
// valid/ready channel interfaces for request and result transactions
// depends on sqwt_pkg for field widths
interface sqwt_in_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [sqwt_pkg::ID_W-1:0]   thread_id;
    logic [sqwt_pkg::TICK_W-1:0] tick_value;

    modport source (output valid, output req_type, output thread_id, output tick_value,
                    input ready);
    modport sink   (input valid, input req_type, input thread_id, input tick_value,
                    output ready);
endinterface

interface sqwt_out_if;
    logic                         valid;
    logic                         ready;
    logic [sqwt_pkg::ID_W-1:0]     woken_id;
    logic [sqwt_pkg::STATUS_W-1:0] status;
    logic [sqwt_pkg::TICK_W-1:0]   earliest_wake;
    logic                         last;

    modport source (output valid, output woken_id, output status, output earliest_wake,
                    output last, input ready);
    modport sink   (input valid, input woken_id, input status, input earliest_wake,
                    input last, output ready);
endinterface

// File: src/sleep_queue_wakeup_table.sv
// channel   dir  modport   payload
// i_in      in   sink      req_type, thread_id, tick_value
// o_out     out  source    woken_id, status, earliest_wake, last
//
// a sleep request is accepted in idle, then the result register loads once the output is free.
// a tick is accepted, then scans the stored sleepers one entry per cycle through the
// registered table read; then a single result is loaded when nobody wakes, or each woken
// thread is loaded in turn (woken-list read, then load, once the output is free).
// reset clears the fill count, the earliest tick and the controller; the rams need none.
// a stalled output holds its result; a new request is taken once the last one is queued.
// top level of the sleep queue wake-up table
// depends on sqwt_pkg, sqwt_if, sqwt_ram, sqwt_ctrl, sqwt_dp and the macros header
`include "sleep_queue_wakeup_table_macros.svh"

module sleep_queue_wakeup_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sqwt_in_if.sink     i_in,
    sqwt_out_if.source  o_out
);

    sqwt_pkg::t_ctl  ctl;
    sqwt_pkg::t_stat stat;

    // controller
    sqwt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_req_type (i_in.req_type),
        .i_stat        (stat),
        .o_in_ready    (i_in.ready),
        .o_ctl         (ctl)
    );

    // datapath
    sqwt_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_thread_id     (i_in.thread_id),
        .i_tick_value    (i_in.tick_value),
        .i_out_ready     (o_out.ready),
        .o_stat          (stat),
        .o_out_valid     (o_out.valid),
        .o_woken_id      (o_out.woken_id),
        .o_status        (o_out.status),
        .o_earliest_wake (o_out.earliest_wake),
        .o_last          (o_out.last)
    );

    // a request transaction takes the controller out of idle
    `SQWT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready)
    // the final woken result returns the block to idle
    `SQWT_ASSERT(a_idle_after_last, i_clk, i_rst_n, (ctl.emit_load && stat.emit_last) |=> i_in.ready)
    // only woken results may continue a sequence
    `SQWT_ASSERT(a_single_is_last, i_clk, i_rst_n, (o_out.valid && o_out.status != sqwt_pkg::ST_WOKEN) |-> o_out.last)
    // no scan work while a result is being loaded
    `SQWT_ASSERT_NEVER(a_scan_vs_emit, i_clk, i_rst_n, ctl.scan_step && (ctl.emit_load || ctl.resp_load))

endmodule

// File: src/sqwt_ram.sv
// generic single write port ram with registered read
// no dependencies
module sqwt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sqwt_ctrl.sv
// controller state machine for the sleep queue wake-up table
// depends on sqwt_pkg
module sqwt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_req_type,
    input  sqwt_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output sqwt_pkg::t_ctl  o_ctl
);

    sqwt_pkg::t_state r_state;
    sqwt_pkg::t_state n_state;
    logic             accept;

    assign accept = (r_state == sqwt_pkg::S_IDLE) && i_in_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqwt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sqwt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (i_in_req_type == sqwt_pkg::REQ_TICK) ? sqwt_pkg::S_SCAN
                                                                    : sqwt_pkg::S_RESP;
                end
            end
            sqwt_pkg::S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = i_stat.any_woken ? sqwt_pkg::S_EMIT_RD : sqwt_pkg::S_RESP;
                end
            end
            sqwt_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = sqwt_pkg::S_IDLE;
                end
            end
            sqwt_pkg::S_EMIT_RD: begin
                n_state = sqwt_pkg::S_EMIT_WR;
            end
            sqwt_pkg::S_EMIT_WR: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_last ? sqwt_pkg::S_IDLE : sqwt_pkg::S_EMIT_RD;
                end
            end
            default: begin
                n_state = sqwt_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sqwt_pkg::S_IDLE: begin
                o_in_ready       = 1'b1;
                o_ctl.load_sleep = accept && (i_in_req_type == sqwt_pkg::REQ_SLEEP);
                o_ctl.load_tick  = accept && (i_in_req_type == sqwt_pkg::REQ_TICK);
            end
            sqwt_pkg::S_SCAN: begin
                o_ctl.scan_step   = !i_stat.scan_done;
                o_ctl.scan_finish = i_stat.scan_done;
            end
            sqwt_pkg::S_RESP: begin
                o_ctl.resp_load = i_stat.out_free;
            end
            sqwt_pkg::S_EMIT_RD: begin
                o_ctl.emit_read = 1'b1;
            end
            sqwt_pkg::S_EMIT_WR: begin
                o_ctl.emit_load = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/sqwt_dp.sv
// datapath: sleeper table, woken list, scan counters and result register
// depends on sqwt_pkg and sqwt_ram
module sqwt_dp #(
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sqwt_pkg::t_ctl                  i_ctl,
    input  logic [sqwt_pkg::ID_W-1:0]       i_thread_id,
    input  logic [sqwt_pkg::TICK_W-1:0]     i_tick_value,
    input  logic                            i_out_ready,
    output sqwt_pkg::t_stat                 o_stat,
    output logic                            o_out_valid,
    output logic [sqwt_pkg::ID_W-1:0]       o_woken_id,
    output logic [sqwt_pkg::STATUS_W-1:0]   o_status,
    output logic [sqwt_pkg::TICK_W-1:0]     o_earliest_wake,
    output logic                            o_last
);

    localparam int IW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int EW  = sqwt_pkg::ID_W + sqwt_pkg::TICK_W;

    // control state
    logic [CW-1:0]                 r_count,     n_count;
    logic [sqwt_pkg::TICK_W-1:0]   r_earliest,  n_earliest;
    logic [CW-1:0]                 r_rd_idx,    n_rd_idx;
    logic                          r_rd_vld,    n_rd_vld;
    logic [CW-1:0]                 r_keep,      n_keep;
    logic [CW-1:0]                 r_wcnt,      n_wcnt;
    logic [CW-1:0]                 r_emit_idx,  n_emit_idx;
    logic                          r_out_valid, n_out_valid;
    // payload state
    logic [sqwt_pkg::TICK_W-1:0]   r_tv,        n_tv;
    logic [sqwt_pkg::TICK_W-1:0]   r_newmin,    n_newmin;
    logic [sqwt_pkg::STATUS_W-1:0] r_resp_st,   n_resp_st;
    logic [sqwt_pkg::ID_W-1:0]     r_out_id,    n_out_id;
    logic [sqwt_pkg::STATUS_W-1:0] r_out_st,    n_out_st;
    logic [sqwt_pkg::TICK_W-1:0]   r_out_ew,    n_out_ew;
    logic                          r_out_last,  n_out_last;

    // ram ports
    logic                          tbl_we;
    logic [IW-1:0]                 tbl_waddr;
    logic [EW-1:0]                 tbl_wdata;
    logic                          tbl_re;
    logic [EW-1:0]                 tbl_rdata;
    logic                          wk_we;
    logic [sqwt_pkg::ID_W-1:0]     wk_rdata;

    logic                          full;
    logic                          issue;
    logic [sqwt_pkg::ID_W-1:0]     ent_id;
    logic [sqwt_pkg::TICK_W-1:0]   ent_tick;
    logic                          ent_keep;
    logic                          out_free;
    logic                          emit_last;

    assign full      = (r_count == CW'(DEPTH));
    assign issue     = i_ctl.scan_step && (r_rd_idx != r_count);
    assign ent_id    = tbl_rdata[EW-1:sqwt_pkg::TICK_W];
    assign ent_tick  = tbl_rdata[sqwt_pkg::TICK_W-1:0];
    assign ent_keep  = ent_tick > r_tv;
    assign out_free  = !r_out_valid || i_out_ready;
    assign emit_last = ((r_emit_idx + CW'(1)) == r_wcnt);

    assign tbl_re = issue;
    assign wk_we  = r_rd_vld && !ent_keep;

    // table write: append on sleep, compaction during scan
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_keep[IW-1:0];
        tbl_wdata = tbl_rdata;
        if (i_ctl.load_sleep) begin
            tbl_we    = !full;
            tbl_waddr = r_count[IW-1:0];
            tbl_wdata = {i_thread_id, i_tick_value};
        end else if (r_rd_vld && ent_keep) begin
            tbl_we = 1'b1;
        end
    end

    sqwt_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (tbl_rdata)
    );

    // woken ids gathered in scan order
    sqwt_ram #(.WIDTH(sqwt_pkg::ID_W), .DEPTH(DEPTH)) u_woken (
        .i_clk   (i_clk),
        .i_we    (wk_we),
        .i_waddr (r_wcnt[IW-1:0]),
        .i_wdata (ent_id),
        .i_re    (i_ctl.emit_read),
        .i_raddr (r_emit_idx[IW-1:0]),
        .o_rdata (wk_rdata)
    );

    // next values
    always_comb begin
        n_count     = r_count;
        n_earliest  = r_earliest;
        n_rd_idx    = r_rd_idx;
        n_rd_vld    = issue;
        n_keep      = r_keep;
        n_wcnt      = r_wcnt;
        n_emit_idx  = r_emit_idx;
        n_tv        = r_tv;
        n_newmin    = r_newmin;
        n_resp_st   = r_resp_st;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_id    = r_out_id;
        n_out_st    = r_out_st;
        n_out_ew    = r_out_ew;
        n_out_last  = r_out_last;

        // sleep request
        if (i_ctl.load_sleep) begin
            if (full) begin
                n_resp_st = sqwt_pkg::ST_FULL;
            end else begin
                n_resp_st = sqwt_pkg::ST_NONE;
                n_count   = r_count + CW'(1);
                if (i_tick_value < r_earliest) begin
                    n_earliest = i_tick_value;
                end
            end
        end

        // tick request starts a scan
        if (i_ctl.load_tick) begin
            n_tv       = i_tick_value;
            n_rd_idx   = '0;
            n_keep     = '0;
            n_wcnt     = '0;
            n_emit_idx = '0;
            n_newmin   = sqwt_pkg::TICK_MAX;
        end

        // scan read address
        if (issue) begin
            n_rd_idx = r_rd_idx + CW'(1);
        end

        // classify the entry read last cycle
        if (r_rd_vld) begin
            if (ent_keep) begin
                n_keep = r_keep + CW'(1);
                if (ent_tick < r_newmin) begin
                    n_newmin = ent_tick;
                end
            end else begin
                n_wcnt = r_wcnt + CW'(1);
            end
        end

        // end of scan
        if (i_ctl.scan_finish) begin
            n_count    = r_keep;
            n_earliest = r_newmin;
            n_resp_st  = sqwt_pkg::ST_NONE;
        end

        // single result
        if (i_ctl.resp_load) begin
            n_out_valid = 1'b1;
            n_out_id    = '0;
            n_out_st    = r_resp_st;
            n_out_ew    = r_earliest;
            n_out_last  = 1'b1;
        end

        // one woken thread
        if (i_ctl.emit_load) begin
            n_out_valid = 1'b1;
            n_out_id    = wk_rdata;
            n_out_st    = sqwt_pkg::ST_WOKEN;
            n_out_ew    = r_earliest;
            n_out_last  = emit_last;
            n_emit_idx  = r_emit_idx + CW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_earliest  <= sqwt_pkg::TICK_MAX;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_keep      <= '0;
            r_wcnt      <= '0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_earliest  <= n_earliest;
            r_rd_idx    <= n_rd_idx;
            r_rd_vld    <= n_rd_vld;
            r_keep      <= n_keep;
            r_wcnt      <= n_wcnt;
            r_emit_idx  <= n_emit_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_tv       <= n_tv;
        r_newmin   <= n_newmin;
        r_resp_st  <= n_resp_st;
        r_out_id   <= n_out_id;
        r_out_st   <= n_out_st;
        r_out_ew   <= n_out_ew;
        r_out_last <= n_out_last;
    end

    assign o_stat.scan_done = (r_rd_idx == r_count) && !r_rd_vld;
    assign o_stat.any_woken = (r_wcnt != '0);
    assign o_stat.emit_last = emit_last;
    assign o_stat.out_free  = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_woken_id      = r_out_id;
    assign o_status        = r_out_st;
    assign o_earliest_wake = r_out_ew;
    assign o_last          = r_out_last;

endmodule

// File: sim/sleep_queue_wakeup_table_tb.sv
// self-checking testbench for the sleep queue wake-up table
// depends on sqwt_pkg, sqwt_if and the sleep_queue_wakeup_table rtl
module sleep_queue_wakeup_table_tb;

    localparam int SLEEP_SLOTS  = 16;
    localparam int PHASE_ITEMS  = 70;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        logic                        req_type;
        logic [sqwt_pkg::ID_W-1:0]   thread_id;
        logic [sqwt_pkg::TICK_W-1:0] tick_value;
    } t_sleep_req;

    typedef struct {
        logic [sqwt_pkg::ID_W-1:0]     woken_id;
        logic [sqwt_pkg::STATUS_W-1:0] status;
        logic [sqwt_pkg::TICK_W-1:0]   earliest_wake;
        logic                          last;
    } t_wake_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sqwt_in_if  in_ch ();
    sqwt_out_if out_ch ();

    sleep_queue_wakeup_table #(
        .TABLE_DEPTH(SLEEP_SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // requests waiting to be sent and results still owed by the block
    t_sleep_req   request_queue[$];
    t_wake_result due_results[$];

    // shadow copy of the sleeper table
    logic [sqwt_pkg::ID_W-1:0]   sleeper_id_tbl   [SLEEP_SLOTS];
    logic [sqwt_pkg::TICK_W-1:0] sleeper_tick_tbl [SLEEP_SLOTS];
    int unsigned                 sleeper_total;
    logic [sqwt_pkg::TICK_W-1:0] earliest_pending;

    int unsigned                 send_idle_pct;
    int unsigned                 recv_stall_pct;
    int unsigned                 requests_built;
    int unsigned                 mismatch_count;
    int unsigned                 cycle_count;
    logic [sqwt_pkg::TICK_W-1:0] clock_now;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // update the shadow table for one accepted transaction and queue its results
    function automatic void update_sleep_table(logic req, logic [sqwt_pkg::ID_W-1:0] id,
                                               logic [sqwt_pkg::TICK_W-1:0] tv);
        logic [sqwt_pkg::ID_W-1:0]   woken[$];
        int unsigned                 keep;
        logic [sqwt_pkg::TICK_W-1:0] new_min;
        if (req == sqwt_pkg::REQ_SLEEP) begin
            if (sleeper_total >= SLEEP_SLOTS) begin
                due_results.push_back('{'0, sqwt_pkg::ST_FULL, earliest_pending, 1'b1});
                return;
            end
            sleeper_id_tbl[sleeper_total]   = id;
            sleeper_tick_tbl[sleeper_total] = tv;
            sleeper_total++;
            if (tv < earliest_pending) earliest_pending = tv;
            due_results.push_back('{'0, sqwt_pkg::ST_NONE, earliest_pending, 1'b1});
            return;
        end
        // tick: release expired sleepers in entry order, compact the rest
        keep    = 0;
        new_min = sqwt_pkg::TICK_MAX;
        for (int i = 0; i < sleeper_total; i++) begin
            if (sleeper_tick_tbl[i] > tv) begin
                if (sleeper_tick_tbl[i] < new_min) new_min = sleeper_tick_tbl[i];
                sleeper_id_tbl[keep]   = sleeper_id_tbl[i];
                sleeper_tick_tbl[keep] = sleeper_tick_tbl[i];
                keep++;
            end else begin
                woken.push_back(sleeper_id_tbl[i]);
            end
        end
        sleeper_total    = keep;
        earliest_pending = new_min;
        if (woken.size() == 0) begin
            due_results.push_back('{'0, sqwt_pkg::ST_NONE, earliest_pending, 1'b1});
            return;
        end
        foreach (woken[i])
            due_results.push_back('{woken[i], sqwt_pkg::ST_WOKEN, earliest_pending,
                                    (i == woken.size() - 1)});
    endfunction

    function automatic logic [sqwt_pkg::TICK_W-1:0] random_tick();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[sqwt_pkg::TICK_W-1:0];
    endfunction

    function automatic void push_sleep(logic [sqwt_pkg::ID_W-1:0] id,
                                       logic [sqwt_pkg::TICK_W-1:0] tv);
        request_queue.push_back('{sqwt_pkg::REQ_SLEEP, id, tv});
        requests_built++;
    endfunction

    // thread id is don't-care on a tick, so it is randomized
    function automatic void push_tick(logic [sqwt_pkg::TICK_W-1:0] tv);
        request_queue.push_back('{sqwt_pkg::REQ_TICK,
                                  sqwt_pkg::ID_W'($urandom_range(0, 65535)), tv});
        requests_built++;
    endfunction

    // a run of sleepers around the current time, usually closed by a tick
    function automatic void add_sleep_burst();
        int n;
        int pick;
        n = $urandom_range(1, 18);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 8)
                push_sleep(sqwt_pkg::ID_W'($urandom_range(0, 65535)),
                           clock_now + $urandom_range(0, 200));
            else
                push_sleep(sqwt_pkg::ID_W'($urandom_range(0, 65535)), random_tick());
        end
        if ($urandom_range(0, 3) == 0) return;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            push_tick(clock_now + $urandom_range(0, 250));
            clock_now += $urandom_range(50, 200);
        end else if (pick == 7) begin
            push_tick(random_tick());
        end else if (pick == 8) begin
            push_tick(sqwt_pkg::TICK_MAX);
        end else begin
            push_tick(sqwt_pkg::TICK_W'($urandom_range(0, 3)));
        end
    endfunction

    task automatic wait_drain();
        @(negedge i_clk);
        while (request_queue.size() != 0 || due_results.size() != 0 || in_ch.valid)
            @(negedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin : req_driver
        logic took;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            took = in_ch.valid && in_ch.ready;
            if (took) void'(request_queue.pop_front());
            if (!in_ch.valid || took) begin
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_ch.valid      <= 1'b1;
                    in_ch.req_type   <= request_queue[0].req_type;
                    in_ch.thread_id  <= request_queue[0].thread_id;
                    in_ch.tick_value <= request_queue[0].tick_value;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: predict on request accept, then check the result transaction
    always @(posedge i_clk) begin : result_monitor
        t_wake_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                update_sleep_table(in_ch.req_type, in_ch.thread_id, in_ch.tick_value);
            if (out_ch.valid && out_ch.ready) begin
                if (due_results.size() == 0) begin
                    $error("result transaction with none expected");
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    if (out_ch.woken_id !== want.woken_id) begin
                        $error("woken_id: expected %0d, got %0d", want.woken_id,
                               out_ch.woken_id);
                        mismatch_count++;
                    end
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        mismatch_count++;
                    end
                    if (out_ch.earliest_wake !== want.earliest_wake) begin
                        $error("earliest_wake: expected %0h, got %0h", want.earliest_wake,
                               out_ch.earliest_wake);
                        mismatch_count++;
                    end
                    if (out_ch.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, out_ch.last);
                        mismatch_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus and end of test
    initial begin
        int target;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.req_type   = sqwt_pkg::REQ_SLEEP;
        in_ch.thread_id  = '0;
        in_ch.tick_value = '0;
        out_ch.ready     = 1'b0;
        sleeper_total    = 0;
        earliest_pending = sqwt_pkg::TICK_MAX;
        mismatch_count   = 0;
        cycle_count      = 0;
        requests_built   = 0;
        send_idle_pct    = 11;
        recv_stall_pct   = 82;
        clock_now        = sqwt_pkg::TICK_W'($urandom_range(100, 1000));

        // tick on an empty table, extremes of id and tick, then wake the zero tick
        push_tick('0);
        push_sleep('0, sqwt_pkg::TICK_MAX);
        push_sleep('1, '0);
        push_tick('0);
        // fill the table out of tick order, with a duplicate id
        for (int k = 0; k < 15; k++)
            push_sleep((k == 7) ? sqwt_pkg::ID_W'(0) : sqwt_pkg::ID_W'(16'h1000 + k),
                       sqwt_pkg::TICK_W'((k * 37) % 60 + 10));
        // full table refuses, earliest tick must not move
        push_sleep(16'hABCD, sqwt_pkg::TICK_W'(5));
        // partial wake with compaction, then wake everyone
        push_tick(sqwt_pkg::TICK_W'(40));
        push_tick(sqwt_pkg::TICK_MAX);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        target = requests_built + PHASE_ITEMS;
        while (requests_built < target) add_sleep_burst();
        wait_drain();

        // sender mostly idle, receiver mostly ready
        send_idle_pct  = 82;
        recv_stall_pct = 11;
        clock_now      = random_tick() >> 1;
        target = requests_built + PHASE_ITEMS;
        while (requests_built < target) add_sleep_burst();
        wait_drain();

        // full rate both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        clock_now      = random_tick() >> 1;
        target = requests_built + PHASE_ITEMS;
        while (requests_built < target) add_sleep_burst();
        wait_drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/sqwt_pkg.sv
src/sqwt_if.sv
src/sqwt_ram.sv
src/sqwt_ctrl.sv
src/sqwt_dp.sv
src/sleep_queue_wakeup_table.sv
sim/sleep_queue_wakeup_table_tb.sv
